@@ design/aiws_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package aiws_pkg;

	// Built depth of the entry store.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the ports, and the compare widths derived from them.
	localparam int MODE_W   = 3;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;
	localparam int CAP_W    = 5;
	localparam int OCNT_W   = 5;
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int LIM_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_END   = 3'd0,
		MODE_FRONT = 3'd1,
		MODE_POS   = 3'd2,
		MODE_SORT  = 3'd3,
		MODE_READ  = 3'd4
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SH_RD,
		S_SH,
		S_PLACE,
		S_RD,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage
`default_nettype wire

@@ design/array_insert_with_shift.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sorted insertion array of signed 32-bit entries with an element count. Each
// request inserts at the end, at the front, at a position, or in signed sorted
// order, or reads one entry back, and returns one result transaction. The
// entries live in a single-port-write, registered-read RAM, and one sequencer
// walks it an entry per cycle: a sorted search reads entries from zero up to the
// slot, or up to the count when the value goes to the end, and the upward shift
// moves the count-slot entries at and above the slot. The input is not ready
// while a request is in progress; a finished result waits in the output
// register, so the next request can start before the previous result is taken.
// The capacity register may be written at any time the block is idle; values
// above the built depth are limited to it.
module array_insert_with_shift (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [aiws_pkg::CAP_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [aiws_pkg::MODE_W-1:0]        mode,
	input  wire logic [aiws_pkg::POS_W-1:0]         position,
	input  wire logic signed [aiws_pkg::DATA_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [aiws_pkg::STAT_W-1:0]             status,
	output logic [aiws_pkg::OCNT_W-1:0]             count_after,
	output logic [aiws_pkg::OCNT_W-1:0]             slot_index,
	output logic signed [aiws_pkg::DATA_W-1:0]      read_value
);

	logic [aiws_pkg::CAP_W-1:0]  capacity_q;
	aiws_pkg::mem_req_t          mem_req;
	logic [aiws_pkg::DATA_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= aiws_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	aiws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity    (capacity_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.count_after (count_after),
		.slot_index  (slot_index),
		.read_value  (read_value),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	aiws_ram #(
		.WIDTH (aiws_pkg::DATA_W),
		.DEPTH (aiws_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

@@ design/aiws_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module aiws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/aiws_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module aiws_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [aiws_pkg::CAP_W-1:0]     capacity,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [aiws_pkg::MODE_W-1:0]    mode,
	input  wire logic [aiws_pkg::POS_W-1:0]     position,
	input  wire logic signed [aiws_pkg::DATA_W-1:0] value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [aiws_pkg::STAT_W-1:0]         status,
	output logic [aiws_pkg::OCNT_W-1:0]         count_after,
	output logic [aiws_pkg::OCNT_W-1:0]         slot_index,
	output logic signed [aiws_pkg::DATA_W-1:0]  read_value,
	output aiws_pkg::mem_req_t                  mem_req,
	input  wire logic [aiws_pkg::DATA_W-1:0]    mem_rdata
);

	localparam int CNT_W = aiws_pkg::CNT_W;
	localparam int IDX_W = aiws_pkg::IDX_W;
	localparam int CMP_W = aiws_pkg::CMP_W;
	localparam int LIM_W = aiws_pkg::LIM_W;

	aiws_pkg::state_t state_q, state_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] k_q, k_n;
	logic [CNT_W-1:0] i_q, i_n;
	logic [aiws_pkg::DATA_W-1:0] val_q, val_n;
	logic [aiws_pkg::DATA_W-1:0] rd_q, rd_n;
	aiws_pkg::status_t stat_q, stat_n;
	logic out_valid_q, out_valid_n;
	logic load_out;

	logic [aiws_pkg::STAT_W-1:0] status_q;
	logic [aiws_pkg::OCNT_W-1:0] count_after_q;
	logic [aiws_pkg::OCNT_W-1:0] slot_index_q;
	logic [aiws_pkg::DATA_W-1:0] read_value_q;

	logic [LIM_W-1:0] limit;
	logic             full;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CNT_W-1:0] k_inc;

	assign limit = (LIM_W'(capacity) > LIM_W'(aiws_pkg::DEPTH)) ?
		LIM_W'(aiws_pkg::DEPTH) : LIM_W'(capacity);
	assign full  = LIM_W'(count_q) >= limit;
	assign pos_w = CMP_W'(position);
	assign cnt_w = CMP_W'(count_q);
	assign k_inc = k_q + CNT_W'(1);

	assign in_ready    = (state_q == aiws_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count_after = count_after_q;
	assign slot_index  = slot_index_q;
	assign read_value  = read_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aiws_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			count_q     <= count_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_n;
		i_q    <= i_n;
		val_q  <= val_n;
		rd_q   <= rd_n;
		stat_q <= stat_n;
		if (load_out) begin
			status_q      <= stat_q;
			count_after_q <= aiws_pkg::OCNT_W'(count_q);
			slot_index_q  <= aiws_pkg::OCNT_W'(k_q);
			read_value_q  <= rd_q;
		end
	end

	always_comb begin
		state_n       = state_q;
		count_n       = count_q;
		k_n           = k_q;
		i_n           = i_q;
		val_n         = val_q;
		rd_n          = rd_q;
		stat_n        = stat_q;
		load_out      = 1'b0;
		out_valid_n   = out_valid_q && !out_ready;
		mem_req.we    = 1'b0;
		mem_req.waddr = i_q[IDX_W-1:0];
		mem_req.wdata = mem_rdata;
		mem_req.raddr = k_q[IDX_W-1:0];

		unique case (state_q)
			aiws_pkg::S_IDLE: begin
				if (in_valid) begin
					val_n  = value;
					rd_n   = '0;
					k_n    = '0;
					stat_n = aiws_pkg::ST_OK;
					state_n = aiws_pkg::S_SH_RD;
					unique case (mode)
						aiws_pkg::MODE_END: begin
							if (full) begin
								stat_n  = aiws_pkg::ST_FULL;
								state_n = aiws_pkg::S_FINISH;
							end else begin
								k_n = count_q;
							end
						end
						aiws_pkg::MODE_FRONT: begin
							if (full) begin
								stat_n  = aiws_pkg::ST_FULL;
								state_n = aiws_pkg::S_FINISH;
							end
						end
						aiws_pkg::MODE_POS: begin
							if (pos_w > cnt_w) begin
								stat_n  = aiws_pkg::ST_BADPOS;
								state_n = aiws_pkg::S_FINISH;
							end else if (full) begin
								stat_n  = aiws_pkg::ST_FULL;
								state_n = aiws_pkg::S_FINISH;
							end else begin
								k_n = CNT_W'(position);
							end
						end
						aiws_pkg::MODE_SORT: begin
							if (full) begin
								stat_n  = aiws_pkg::ST_FULL;
								state_n = aiws_pkg::S_FINISH;
							end else if (count_q != '0) begin
								// Fetch entry zero so the compare starts next cycle.
								mem_req.raddr = '0;
								state_n       = aiws_pkg::S_SRCH;
							end
						end
						aiws_pkg::MODE_READ: begin
							if (pos_w >= cnt_w) begin
								stat_n  = aiws_pkg::ST_BADPOS;
								state_n = aiws_pkg::S_FINISH;
							end else begin
								k_n           = CNT_W'(position);
								mem_req.raddr = position[IDX_W-1:0];
								state_n       = aiws_pkg::S_RD;
							end
						end
						default: begin
							stat_n  = aiws_pkg::ST_BADPOS;
							state_n = aiws_pkg::S_FINISH;
						end
					endcase
				end
			end
			aiws_pkg::S_SRCH: begin
				// The read data holds entry k; the next entry is fetched meanwhile.
				mem_req.raddr = k_inc[IDX_W-1:0];
				if ($signed(mem_rdata) < $signed(val_q)) begin
					k_n = k_inc;
					if (k_inc == count_q) begin
						state_n = aiws_pkg::S_SH_RD;
					end
				end else begin
					state_n = aiws_pkg::S_SH_RD;
				end
			end
			aiws_pkg::S_SH_RD: begin
				if (count_q > k_q) begin
					i_n           = count_q;
					mem_req.raddr = IDX_W'(count_q - CNT_W'(1));
					state_n       = aiws_pkg::S_SH;
				end else begin
					state_n = aiws_pkg::S_PLACE;
				end
			end
			aiws_pkg::S_SH: begin
				// Move entry i-1 up to slot i while fetching entry i-2.
				mem_req.we    = 1'b1;
				mem_req.waddr = i_q[IDX_W-1:0];
				mem_req.wdata = mem_rdata;
				mem_req.raddr = IDX_W'(i_q - CNT_W'(2));
				if ((i_q - CNT_W'(1)) == k_q) begin
					state_n = aiws_pkg::S_PLACE;
				end else begin
					i_n = i_q - CNT_W'(1);
				end
			end
			aiws_pkg::S_PLACE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q[IDX_W-1:0];
				mem_req.wdata = val_q;
				count_n       = count_q + CNT_W'(1);
				state_n       = aiws_pkg::S_FINISH;
			end
			aiws_pkg::S_RD: begin
				rd_n    = mem_rdata;
				state_n = aiws_pkg::S_FINISH;
			end
			aiws_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out    = 1'b1;
					out_valid_n = 1'b1;
					state_n     = aiws_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = aiws_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/sv/array_insert_with_shift_test.sv @@
`timescale 1ns / 1ps

typedef struct packed {
	aiws_pkg::status_t                  status;
	logic [aiws_pkg::OCNT_W-1:0]        count_after;
	logic [aiws_pkg::OCNT_W-1:0]        slot_index;
	logic signed [aiws_pkg::DATA_W-1:0] read_value;
} table_reply_t;

class insert_tracker;
	logic signed [aiws_pkg::DATA_W-1:0] slots [aiws_pkg::DEPTH];
	int unsigned                        fill;
	int unsigned                        capacity;
	int unsigned                        failures;
	table_reply_t                       expected_replies [$];

	localparam int unsigned MAX_SHOWN = 10;

	function new();
		fill = 0;
		capacity = 32'(aiws_pkg::CAP_RESET);
		failures = 0;
	endfunction

	function int unsigned pending();
		return expected_replies.size();
	endfunction

	// Opens a hole at slot k and drops the value into it.
	function void place_value(int unsigned k, logic signed [aiws_pkg::DATA_W-1:0] val);
		for (int unsigned i = fill; i > k; i--)
			slots[i] = slots[i-1];
		slots[k] = val;
		fill++;
	endfunction

	function void record_request(logic [aiws_pkg::MODE_W-1:0] m,
			logic [aiws_pkg::POS_W-1:0] pos, logic signed [aiws_pkg::DATA_W-1:0] val);
		table_reply_t r;
		int unsigned  lim;
		int unsigned  k;
		int unsigned  p;
		bit           full;
		r.status = aiws_pkg::ST_OK;
		r.slot_index = '0;
		r.read_value = '0;
		p = 32'(pos);
		lim = (capacity > 32'(aiws_pkg::DEPTH)) ? 32'(aiws_pkg::DEPTH) : capacity;
		full = (fill >= lim);
		case (m) inside
			aiws_pkg::MODE_END, aiws_pkg::MODE_FRONT: begin
				if (full) begin
					r.status = aiws_pkg::ST_FULL;
				end else begin
					k = (m == aiws_pkg::MODE_END) ? fill : 0;
					place_value(k, val);
					r.slot_index = aiws_pkg::OCNT_W'(k);
				end
			end
			aiws_pkg::MODE_POS: begin
				// The position check takes priority over the full check.
				if (p > fill) begin
					r.status = aiws_pkg::ST_BADPOS;
				end else if (full) begin
					r.status = aiws_pkg::ST_FULL;
				end else begin
					place_value(p, val);
					r.slot_index = aiws_pkg::OCNT_W'(p);
				end
			end
			aiws_pkg::MODE_SORT: begin
				if (full) begin
					r.status = aiws_pkg::ST_FULL;
				end else begin
					k = 0;
					while (k < fill && slots[k] < val)
						k++;
					place_value(k, val);
					r.slot_index = aiws_pkg::OCNT_W'(k);
				end
			end
			aiws_pkg::MODE_READ: begin
				if (p >= fill) begin
					r.status = aiws_pkg::ST_BADPOS;
				end else begin
					r.slot_index = aiws_pkg::OCNT_W'(p);
					r.read_value = slots[p];
				end
			end
			default: r.status = aiws_pkg::ST_BADPOS;
		endcase
		r.count_after = aiws_pkg::OCNT_W'(fill);
		expected_replies.push_back(r);
	endfunction

	function void check_reply(logic [aiws_pkg::STAT_W-1:0] st,
			logic [aiws_pkg::OCNT_W-1:0] cnt, logic [aiws_pkg::OCNT_W-1:0] slot,
			logic signed [aiws_pkg::DATA_W-1:0] rd);
		table_reply_t e;
		if (expected_replies.size() == 0) begin
			failures++;
			if (failures <= MAX_SHOWN)
				$display("unexpected result: status=%0d count=%0d slot=%0d value=%0d",
					st, cnt, slot, rd);
			return;
		end
		e = expected_replies.pop_front();
		if (st !== e.status || cnt !== e.count_after || slot !== e.slot_index ||
				rd !== e.read_value) begin
			failures++;
			if (failures <= MAX_SHOWN)
				$display({"mismatch: expected status=%0d count=%0d slot=%0d value=%0d,",
					" got status=%0d count=%0d slot=%0d value=%0d"},
					e.status, e.count_after, e.slot_index, e.read_value,
					st, cnt, slot, rd);
		end
	endfunction
endclass

module array_insert_with_shift_test;

	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned STALL_LIMIT   = 5000;

	// Mode codes that the block does not implement.
	localparam logic [aiws_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [aiws_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [aiws_pkg::CAP_W-1:0]         cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [aiws_pkg::MODE_W-1:0]        mode = '0;
	logic [aiws_pkg::POS_W-1:0]         position = '0;
	logic signed [aiws_pkg::DATA_W-1:0] value = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [aiws_pkg::STAT_W-1:0]        status;
	logic [aiws_pkg::OCNT_W-1:0]        count_after;
	logic [aiws_pkg::OCNT_W-1:0]        slot_index;
	logic signed [aiws_pkg::DATA_W-1:0] read_value;

	int unsigned   send_idle_pct = 0;
	int unsigned   stall_pct = 0;
	int unsigned   hold_requests = 0;
	insert_tracker table_sb;

	always #5 clk = ~clk;

	array_insert_with_shift u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.count_after (count_after),
		.slot_index  (slot_index),
		.read_value  (read_value)
	);

	// Results are checked before the same edge's request is recorded, so a
	// spurious result can never pair with a request accepted in that cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				table_sb.capacity = 32'(cfg_data);
			if (out_valid && out_ready)
				table_sb.check_reply(status, count_after, slot_index, read_value);
			if (in_valid && in_ready)
				table_sb.record_request(mode, position, value);
		end
	end

	initial begin
		int unsigned served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				// Long hold-off so that the block backs up into its input.
				served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic send_item(logic [aiws_pkg::MODE_W-1:0] m, logic [aiws_pkg::POS_W-1:0] p,
			logic signed [aiws_pkg::DATA_W-1:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		position <= p;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (table_sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [aiws_pkg::CAP_W-1:0] cap);
		wait_for_replies();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item();
		int unsigned                        pick;
		int unsigned                        cnt;
		logic [aiws_pkg::MODE_W-1:0]        m;
		logic [aiws_pkg::POS_W-1:0]         p;
		logic signed [aiws_pkg::DATA_W-1:0] v;
		cnt = table_sb.fill;
		pick = $urandom_range(99);
		p = aiws_pkg::POS_W'($urandom);
		v = $urandom;
		// Small values make equal keys common for the sorted search.
		if ($urandom_range(3) == 0) begin
			v = $urandom_range(16);
			v = v - 8;
		end
		if (pick < 12) begin
			m = aiws_pkg::MODE_END;
		end else if (pick < 24) begin
			m = aiws_pkg::MODE_FRONT;
		end else if (pick < 40) begin
			m = aiws_pkg::MODE_POS;
			pick = $urandom_range(99);
			if (pick < 75)
				p = aiws_pkg::POS_W'($urandom_range(cnt));
			else if (pick < 90)
				p = aiws_pkg::POS_W'(cnt + 1);
		end else if (pick < 56) begin
			m = aiws_pkg::MODE_SORT;
		end else if (pick < 95) begin
			m = aiws_pkg::MODE_READ;
			if (cnt > 0 && $urandom_range(99) < 80)
				p = aiws_pkg::POS_W'($urandom_range(cnt - 1));
		end else begin
			m = aiws_pkg::MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
		end
		send_item(m, p, v);
	endtask

	task automatic run_phase(logic [aiws_pkg::CAP_W-1:0] cap, int unsigned send_pct,
			int unsigned recv_pct, int unsigned n, bit with_hold);
		write_capacity(cap);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
		if (with_hold)
			hold_requests <= hold_requests + 1;
		for (int unsigned i = 0; i < n; i++) begin
			send_random_item();
			if (i % 100 == 99)
				wait_for_replies();
		end
	endtask

	initial begin
		table_sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no usable slots every insert is refused; bad positions still win.
		write_capacity(5'd0);
		send_item(aiws_pkg::MODE_END, 8'd0, 32'sd1);
		send_item(aiws_pkg::MODE_POS, 8'd0, 32'sd2);
		send_item(aiws_pkg::MODE_POS, 8'd1, 32'sd3);
		send_item(aiws_pkg::MODE_POS, 8'd255, 32'sd4);
		send_item(aiws_pkg::MODE_READ, 8'd0, 32'sd0);
		send_item(MODE_UNUSED_LO, 8'd0, 32'sd0);
		send_item(MODE_UNUSED_HI, 8'd255, -32'sd1);

		write_capacity(5'd4);
		send_item(aiws_pkg::MODE_SORT, 8'd0, 32'sd5);
		send_item(aiws_pkg::MODE_SORT, 8'd0, -32'sd7);
		send_item(aiws_pkg::MODE_SORT, 8'd0, 32'sd5);
		send_item(aiws_pkg::MODE_END, 8'd0, 32'h7fff_ffff);
		send_item(aiws_pkg::MODE_FRONT, 8'd0, 32'sd1);
		send_item(aiws_pkg::MODE_POS, 8'd5, 32'sd1);
		send_item(aiws_pkg::MODE_POS, 8'd4, 32'sd1);
		send_item(aiws_pkg::MODE_READ, 8'd0, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd1, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd2, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd3, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd4, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd255, 32'sd0);

		// A capacity above the built depth is limited by the depth.
		write_capacity(5'd31);
		send_item(aiws_pkg::MODE_FRONT, 8'd0, 32'h8000_0000);
		send_item(aiws_pkg::MODE_POS, 8'd2, -32'sd1);
		send_item(aiws_pkg::MODE_POS, 8'd6, 32'sd0);
		send_item(aiws_pkg::MODE_SORT, 8'd0, 32'h8000_0000);
		send_item(aiws_pkg::MODE_SORT, 8'd0, 32'h7fff_ffff);
		send_item(aiws_pkg::MODE_READ, 8'd0, 32'sd0);
		send_item(aiws_pkg::MODE_READ, 8'd8, 32'sd0);

		run_phase(5'd10, 0, 0, 200, 1'b0);
		run_phase(5'd13, 53, 0, 200, 1'b1);
		run_phase(5'd31, 0, 53, 250, 1'b0);
		run_phase(5'd16, 14, 14, 250, 1'b0);
		// Capacity below the count: inserts are refused, reads keep working.
		run_phase(5'd2, 0, 0, 150, 1'b0);
		run_phase(5'd0, 0, 53, 100, 1'b0);
		run_phase(5'd16, 14, 14, 150, 1'b0);

		wait_for_replies();
		if (table_sb.failures == 0 && table_sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/aiws_pkg.sv
design/aiws_ram.sv
design/aiws_ctrl.sv
design/array_insert_with_shift.sv
tb/sv/array_insert_with_shift_test.sv
